[src/sacs_pkg.sv]
package sacs_pkg;

  // Default block length in frames.
  localparam int unsigned MAX_FRAMES_DEF = 64;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAME_W    = 2 * SAMPLE_W;
  localparam int unsigned RATIO_W    = 10;
  localparam int unsigned PER_MILLE  = 1000;
  localparam int unsigned MILLE_W    = $clog2(PER_MILLE + 1);
  localparam int unsigned NUM_CUTS   = 6;
  localparam int unsigned CUT_W      = 10;
  localparam int unsigned NUM_LEVELS = NUM_CUTS + 1;
  localparam int unsigned LEVEL_W    = $clog2(NUM_LEVELS);
  localparam int unsigned THR_W      = 16;
  localparam int unsigned DIV_CNT_W  = $clog2(RATIO_W + 1);

  // Configuration port.
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_CUTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH   = 2'd3;

  localparam int unsigned SMALL_STEP_W = 16;
  localparam int unsigned RATIO_CUTS_W = 60;
  localparam int unsigned THR_LOW_W    = 64;
  localparam int unsigned THR_HIGH_W   = 48;

  localparam logic [SMALL_STEP_W-1:0] SMALL_STEP_RST = 16'd256;
  localparam logic [RATIO_CUTS_W-1:0] RATIO_CUTS_RST = 60'd541092387824134020;
  localparam logic [THR_LOW_W-1:0]    THR_LOW_RST    = 64'd422216760082432500;
  localparam logic [THR_HIGH_W-1:0]   THR_HIGH_RST   = 48'd17180065794000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SEL,
    ST_FETCH,
    ST_EMIT
  } sacs_state_e;

endpackage

[src/stereo_adaptive_click_suppressor_top.sv]
// Loading: one frame transaction per cycle while busy is low; a frame that
// closes the block (last mark or full store) raises busy on the next cycle.
// After the closing transaction the block multiplies, divides, picks the
// threshold and primes the read port, then gives one result per cycle. Busy
// spans the divider and the reads through the store's single read port.
// Reset is asynchronous and active low; results cannot be stalled.
module stereo_adaptive_click_suppressor_top #(
  parameter int unsigned MAX_FRAMES = sacs_pkg::MAX_FRAMES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Frame input transaction.
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sacs_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [sacs_pkg::SAMPLE_W-1:0] right_sample_i,
  input  logic                                 last_frame_i,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [sacs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sacs_pkg::CFG_W-1:0]           cfg_data_i,
  // Result transaction, one cycle per strobe.
  output logic                                 out_valid_o,
  output logic signed [sacs_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sacs_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                                 block_end_o
);

  // Widths that follow from the block length. CW holds a frame count up to
  // MAX_FRAMES, SCW the small-step count up to twice that.
  localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned SCW = $clog2(2 * MAX_FRAMES + 1);
  localparam int unsigned PW  = SCW + sacs_pkg::MILLE_W;
  localparam int unsigned SW  = sacs_pkg::SAMPLE_W;
  localparam int unsigned XW  = SW + 1;

  sacs_pkg::sacs_state_e state_q, state_d;

  // Configuration registers.
  logic [sacs_pkg::SMALL_STEP_W-1:0] small_step_q;
  logic [sacs_pkg::RATIO_CUTS_W-1:0] ratio_cuts_q;
  logic [sacs_pkg::THR_LOW_W-1:0]    thr_low_q;
  logic [sacs_pkg::THR_HIGH_W-1:0]   thr_high_q;

  // Block state.
  logic [CW-1:0]          frame_count_q, frame_count_d;
  logic [SCW-1:0]         small_count_q, small_count_d;
  logic signed [SW-1:0]   raw_prev_l_q, raw_prev_l_d, raw_prev_r_q, raw_prev_r_d;
  logic signed [SW-1:0]   out_prev_l_q, out_prev_l_d, out_prev_r_q, out_prev_r_d;
  logic [CW-1:0]          fetch_idx_q, fetch_idx_d;
  logic [CW-1:0]          emit_idx_q, emit_idx_d;
  logic [sacs_pkg::THR_W-1:0]   thr_q, thr_d;
  logic [sacs_pkg::FRAME_W-1:0] cur_q, cur_d;

  // Result registers.
  logic                   out_valid_q, out_valid_d;
  logic signed [SW-1:0]   left_out_q, left_out_d, right_out_q, right_out_d;
  logic                   block_end_q, block_end_d;

  // Loading datapath.
  logic                   accept;
  logic                   close;
  logic [CW-1:0]          fc_inc;
  logic signed [SW-1:0]   base_l, base_r;
  logic signed [XW-1:0]   diff_l, diff_r;
  logic [XW-1:0]          abs_l, abs_r, lim_x;
  logic                   small_l, small_r;

  // Processing datapath.
  logic                   div_start;
  logic                   div_done;
  logic [PW-1:0]          dividend;
  logic [sacs_pkg::RATIO_W-1:0] ratio;
  logic [sacs_pkg::LEVEL_W-1:0] level;
  logic [sacs_pkg::THR_W*sacs_pkg::NUM_LEVELS-1:0] thr_all;
  logic [sacs_pkg::THR_W-1:0]   thr_sel;
  logic [AW-1:0]          rd_addr;
  logic [sacs_pkg::FRAME_W-1:0] rd_data;
  logic                   emit_last;
  logic signed [SW-1:0]   cur_l, cur_r, next_l, next_r, rep_l, rep_r;

  // A frame transaction is taken whenever the block is idle.
  assign accept = start && !busy;
  assign fc_inc = frame_count_q + 1'b1;
  assign close  = last_frame_i || (fc_inc == CW'(MAX_FRAMES));

  // Small-step detection. The first frame of a block compares against the
  // last cleaned output, later frames against the previous raw sample.
  always_comb begin
    base_l  = (frame_count_q == '0) ? out_prev_l_q : raw_prev_l_q;
    base_r  = (frame_count_q == '0) ? out_prev_r_q : raw_prev_r_q;
    diff_l  = $signed({left_sample_i[SW-1], left_sample_i}) - $signed({base_l[SW-1], base_l});
    diff_r  = $signed({right_sample_i[SW-1], right_sample_i})
            - $signed({base_r[SW-1], base_r});
    abs_l   = diff_l[XW-1] ? $unsigned(-diff_l) : $unsigned(diff_l);
    abs_r   = diff_r[XW-1] ? $unsigned(-diff_r) : $unsigned(diff_r);
    lim_x   = {1'b0, small_step_q};
    small_l = (abs_l < lim_x);
    small_r = (abs_r < lim_x);
  end

  // Frame store: one write port for loading, one registered read port for
  // streaming the block back out.
  sacs_store #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (frame_count_q[AW-1:0]),
    .wr_data_i ({right_sample_i, left_sample_i}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Per-mille ratio: the small-step count times 1000 over twice the frame
  // count. The constant product is taken straight into the divider's
  // registers; the quotient never exceeds 1000.
  assign dividend = PW'(small_count_q) * PW'(sacs_pkg::PER_MILLE);

  sacs_divider #(
    .DIVIDEND_W (PW),
    .DIVISOR_W  (CW + 1)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  ({frame_count_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (ratio)
  );

  // Level pick: the first cutoff, strictest first, that the ratio reaches.
  // When none is reached the loosest level applies.
  always_comb begin
    level = sacs_pkg::LEVEL_W'(sacs_pkg::NUM_CUTS);
    for (int k = sacs_pkg::NUM_CUTS - 1; k >= 0; k--) begin
      if (ratio >= ratio_cuts_q[sacs_pkg::CUT_W*k +: sacs_pkg::CUT_W]) begin
        level = sacs_pkg::LEVEL_W'(k);
      end
    end
    thr_all = {thr_high_q, thr_low_q};
    thr_sel = thr_all[sacs_pkg::THR_W*level +: sacs_pkg::THR_W];
  end

  // Emission. cur_q holds frame k and the read port delivers frame k+1; the
  // final frame of a block uses itself as its next sample.
  assign emit_last = (emit_idx_q == frame_count_q - 1'b1);
  assign rd_addr   = (fetch_idx_q < frame_count_q) ? fetch_idx_q[AW-1:0] : '0;

  always_comb begin
    cur_l  = cur_q[SW-1:0];
    cur_r  = cur_q[sacs_pkg::FRAME_W-1:SW];
    next_l = emit_last ? cur_l : rd_data[SW-1:0];
    next_r = emit_last ? cur_r : rd_data[sacs_pkg::FRAME_W-1:SW];
  end

  sacs_repair u_rep_l (
    .cur_i  (cur_l),
    .prev_i (out_prev_l_q),
    .next_i (next_l),
    .thr_i  (thr_q),
    .res_o  (rep_l)
  );

  sacs_repair u_rep_r (
    .cur_i  (cur_r),
    .prev_i (out_prev_r_q),
    .next_i (next_r),
    .thr_i  (thr_q),
    .res_o  (rep_r)
  );

  // Sequencer: load, multiply, divide, pick the threshold, prime the read
  // port, then stream one frame per cycle.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacs_pkg::ST_IDLE: begin
        if (accept && close) begin
          state_d = sacs_pkg::ST_MUL;
        end
      end
      sacs_pkg::ST_MUL:   state_d = sacs_pkg::ST_DIV;
      sacs_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = sacs_pkg::ST_SEL;
        end
      end
      sacs_pkg::ST_SEL:   state_d = sacs_pkg::ST_FETCH;
      sacs_pkg::ST_FETCH: state_d = sacs_pkg::ST_EMIT;
      sacs_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_d = sacs_pkg::ST_IDLE;
        end
      end
      default: state_d = sacs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_q != sacs_pkg::ST_IDLE);
    div_start = (state_q == sacs_pkg::ST_MUL);
  end

  // Next values of the datapath registers.
  always_comb begin
    frame_count_d = frame_count_q;
    small_count_d = small_count_q;
    raw_prev_l_d  = raw_prev_l_q;
    raw_prev_r_d  = raw_prev_r_q;
    out_prev_l_d  = out_prev_l_q;
    out_prev_r_d  = out_prev_r_q;
    fetch_idx_d   = fetch_idx_q;
    emit_idx_d    = emit_idx_q;
    thr_d         = thr_q;
    cur_d         = cur_q;
    out_valid_d   = 1'b0;
    left_out_d    = left_out_q;
    right_out_d   = right_out_q;
    block_end_d   = 1'b0;
    unique case (state_q)
      sacs_pkg::ST_IDLE: begin
        fetch_idx_d = '0;
        if (accept) begin
          frame_count_d = fc_inc;
          small_count_d = small_count_q + SCW'(small_l) + SCW'(small_r);
          raw_prev_l_d  = left_sample_i;
          raw_prev_r_d  = right_sample_i;
        end
      end
      sacs_pkg::ST_MUL, sacs_pkg::ST_DIV: begin
      end
      sacs_pkg::ST_SEL: begin
        thr_d       = thr_sel;
        fetch_idx_d = CW'(fetch_idx_q + 1'b1);
      end
      sacs_pkg::ST_FETCH: begin
        cur_d       = rd_data;
        emit_idx_d  = '0;
        fetch_idx_d = CW'(fetch_idx_q + 1'b1);
      end
      sacs_pkg::ST_EMIT: begin
        cur_d        = rd_data;
        emit_idx_d   = CW'(emit_idx_q + 1'b1);
        fetch_idx_d  = CW'(fetch_idx_q + 1'b1);
        out_prev_l_d = rep_l;
        out_prev_r_d = rep_r;
        out_valid_d  = 1'b1;
        left_out_d   = rep_l;
        right_out_d  = rep_r;
        block_end_d  = emit_last;
        if (emit_last) begin
          frame_count_d = '0;
          small_count_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sacs_pkg::ST_IDLE;
      frame_count_q <= '0;
      small_count_q <= '0;
      raw_prev_l_q  <= '0;
      raw_prev_r_q  <= '0;
      out_prev_l_q  <= '0;
      out_prev_r_q  <= '0;
      fetch_idx_q   <= '0;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      block_end_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      small_count_q <= small_count_d;
      raw_prev_l_q  <= raw_prev_l_d;
      raw_prev_r_q  <= raw_prev_r_d;
      out_prev_l_q  <= out_prev_l_d;
      out_prev_r_q  <= out_prev_r_d;
      fetch_idx_q   <= fetch_idx_d;
      emit_idx_q    <= emit_idx_d;
      out_valid_q   <= out_valid_d;
      block_end_q   <= block_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q       <= thr_d;
    cur_q       <= cur_d;
    left_out_q  <= left_out_d;
    right_out_q <= right_out_d;
  end

  // Configuration writes; the threshold is chosen from whatever values the
  // registers hold at the threshold-pick step, after the division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_step_q <= sacs_pkg::SMALL_STEP_RST;
      ratio_cuts_q <= sacs_pkg::RATIO_CUTS_RST;
      thr_low_q    <= sacs_pkg::THR_LOW_RST;
      thr_high_q   <= sacs_pkg::THR_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacs_pkg::CFG_SMALL_STEP: small_step_q <= cfg_data_i[sacs_pkg::SMALL_STEP_W-1:0];
        sacs_pkg::CFG_RATIO_CUTS: ratio_cuts_q <= cfg_data_i[sacs_pkg::RATIO_CUTS_W-1:0];
        sacs_pkg::CFG_THR_LOW:    thr_low_q    <= cfg_data_i[sacs_pkg::THR_LOW_W-1:0];
        sacs_pkg::CFG_THR_HIGH:   thr_high_q   <= cfg_data_i[sacs_pkg::THR_HIGH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign block_end_o = block_end_q;

endmodule

[src/sacs_store.sv]
module sacs_store #(
  parameter int unsigned DEPTH = sacs_pkg::MAX_FRAMES_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [sacs_pkg::FRAME_W-1:0] wr_data_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [sacs_pkg::FRAME_W-1:0] rd_data_o
);

  logic [sacs_pkg::FRAME_W-1:0] mem_q [DEPTH];
  logic [sacs_pkg::FRAME_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/sacs_divider.sv]
module sacs_divider #(
  parameter int unsigned DIVIDEND_W = 17,
  parameter int unsigned DIVISOR_W  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DIVIDEND_W-1:0]        dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic                         done_o,
  output logic [sacs_pkg::RATIO_W-1:0] quotient_o
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // that the quotient fits in RATIO_W bits, so the remainder always stays
  // below the divisor.
  logic [sacs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [DIVISOR_W-1:0]           rem_q, rem_d;
  logic [DIVISOR_W-1:0]           div_q, div_d;
  logic [sacs_pkg::RATIO_W-1:0]   dvd_q, dvd_d;
  logic [sacs_pkg::RATIO_W-1:0]   quo_q, quo_d;
  logic [DIVISOR_W:0]             trial;
  logic [DIVISOR_W:0]             diff;
  logic                           fits;

  always_comb begin
    trial = {rem_q, dvd_q[sacs_pkg::RATIO_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = sacs_pkg::DIV_CNT_W'(sacs_pkg::RATIO_W);
      rem_d = DIVISOR_W'(dividend_i >> sacs_pkg::RATIO_W);
      dvd_d = dividend_i[sacs_pkg::RATIO_W-1:0];
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == sacs_pkg::DIV_CNT_W'(1));
      rem_d  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dvd_d  = {dvd_q[sacs_pkg::RATIO_W-2:0], 1'b0};
      quo_d  = {quo_q[sacs_pkg::RATIO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/sacs_repair.sv]
module sacs_repair (
  input  logic signed [sacs_pkg::SAMPLE_W-1:0] cur_i,
  input  logic signed [sacs_pkg::SAMPLE_W-1:0] prev_i,
  input  logic signed [sacs_pkg::SAMPLE_W-1:0] next_i,
  input  logic        [sacs_pkg::THR_W-1:0]    thr_i,
  output logic signed [sacs_pkg::SAMPLE_W-1:0] res_o
);

  localparam int unsigned XW = sacs_pkg::SAMPLE_W + 1;

  logic signed [XW-1:0] cur_x, prev_x, next_x;
  logic signed [XW-1:0] step, back, sum, avg_sum, avg;
  logic signed [XW-1:0] half, neg_half, up, dn;
  logic        [XW-1:0] step_abs, back_abs, thr_x;

  always_comb begin
    cur_x    = $signed({cur_i[sacs_pkg::SAMPLE_W-1], cur_i});
    prev_x   = $signed({prev_i[sacs_pkg::SAMPLE_W-1], prev_i});
    next_x   = $signed({next_i[sacs_pkg::SAMPLE_W-1], next_i});
    thr_x    = {1'b0, thr_i};
    step     = cur_x - prev_x;
    back     = next_x - cur_x;
    step_abs = step[XW-1] ? $unsigned(-step) : $unsigned(step);
    back_abs = back[XW-1] ? $unsigned(-back) : $unsigned(back);
    // Average of the previous output and the next raw sample, rounded toward zero.
    sum      = prev_x + next_x;
    avg_sum  = sum + $signed({{(XW-1){1'b0}}, sum[XW-1]});
    avg      = avg_sum >>> 1;
    half     = $signed({2'b00, thr_i[sacs_pkg::THR_W-1:1]});
    neg_half = -half;
    up       = prev_x + half;
    dn       = prev_x - half;
    priority if (step_abs <= thr_x) begin
      res_o = cur_i;
    end else if (back_abs > thr_x && back[XW-1] != step[XW-1]) begin
      res_o = avg[sacs_pkg::SAMPLE_W-1:0];
    end else if (step > half) begin
      res_o = up[sacs_pkg::SAMPLE_W-1:0];
    end else if (step < neg_half) begin
      res_o = dn[sacs_pkg::SAMPLE_W-1:0];
    end else begin
      res_o = cur_i;
    end
  end

endmodule

[src/sacs_checker.sv]
module sacs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_frame_i,
  input logic out_valid_o,
  input logic block_end_o
);

  // A result that is not the block's last one is only shown while streaming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_end_o |-> busy)
    else $error("non-final result while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_end_o |-> out_valid_o)
    else $error("block end without result strobe");

  // Results never follow a frame transaction directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !out_valid_o)
    else $error("result right after a frame transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_frame_i |=> busy)
    else $error("last frame did not start processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |=> !out_valid_o)
    else $error("result after block end");

endmodule

bind stereo_adaptive_click_suppressor_top sacs_checker u_sacs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .last_frame_i (last_frame_i),
  .out_valid_o  (out_valid_o),
  .block_end_o  (block_end_o)
);
